[design/hebrew_calendar_day_conversion_unit_macros.svh]
// assertion macros for the hebrew calendar day conversion unit
// included by the rtl modules that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef HEBREW_CALENDAR_DAY_CONVERSION_UNIT_MACROS_SVH
`define HEBREW_CALENDAR_DAY_CONVERSION_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define HCDC_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);
`define HCDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define HCDC_ASSERT_IMPL(lbl, pre, post, msg)
`define HCDC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[design/hcdc_pkg.sv]
// shared types, constants and month helpers for the hebrew calendar day conversion unit
// no dependencies
package hcdc_pkg;

  localparam logic [23:0] EpochW      = 24'd1373429;
  localparam logic [22:0] Epoch       = 23'd1373429;
  localparam logic [23:0] FirstDayW   = 24'd1;
  localparam logic [13:0] MaxYear     = 14'd9999;
  localparam logic [14:0] EstHigh     = 15'd10001;
  localparam logic [23:0] RecipYear   = 24'd11758000;
  localparam logic [8:0]  YearLenMax  = 9'd385;

  localparam logic [15:0] Recip19     = 16'd55189;
  localparam logic [19:0] Recip1080   = 20'd994206;
  localparam logic [21:0] Recip24     = 22'd2796203;
  localparam logic [22:0] Recip7      = 23'd4793491;
  localparam logic [8:0]  CycleMonths = 9'd235;
  localparam logic [10:0] PartsHour   = 11'd1080;
  localparam logic [9:0]  MoladStep   = 10'd793;
  localparam logic [7:0]  MoladBase   = 8'd204;
  localparam logic [14:0] LimitLate   = 15'd19440;
  localparam logic [14:0] LimitTue    = 15'd9924;
  localparam logic [14:0] LimitMon    = 15'd16789;
  localparam logic [2:0]  WdMon       = 3'd1;
  localparam logic [2:0]  WdTue       = 3'd2;
  localparam logic [2:0]  WdWed       = 3'd3;
  localparam logic [2:0]  WdFri       = 3'd5;

  localparam logic [3:0] MonthNisan   = 4'd1;
  localparam logic [3:0] MonthIyar    = 4'd2;
  localparam logic [3:0] MonthTammuz  = 4'd4;
  localparam logic [3:0] MonthElul    = 4'd6;
  localparam logic [3:0] MonthTishrei = 4'd7;
  localparam logic [3:0] MonthHeshvan = 4'd8;
  localparam logic [3:0] MonthKislev  = 4'd9;
  localparam logic [3:0] MonthTevet   = 4'd10;
  localparam logic [3:0] MonthAdar    = 4'd12;
  localparam logic [3:0] MonthAdarII  = 4'd13;

  typedef struct packed {
    logic        start;
    logic [13:0] year;
  } ny_req_t;

  typedef struct packed {
    logic        done;
    logic [21:0] days;
    logic        leap;
  } ny_rsp_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap,
                                           input logic long_hv, input logic short_kv);
    logic [4:0] len;
    len = 5'd30;
    unique case (m)
      MonthIyar, MonthTammuz, MonthElul, MonthTevet, MonthAdarII: len = 5'd29;
      MonthAdar: if (!leap) len = 5'd29;
      MonthHeshvan: if (!long_hv) len = 5'd29;
      MonthKislev: if (short_kv) len = 5'd29;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] next_month(input logic [3:0] m, input logic leap);
    logic [3:0] nm;
    if ((m == MonthAdar && !leap) || m == MonthAdarII) nm = MonthNisan;
    else nm = m + 4'd1;
    return nm;
  endfunction

  // place in the 19 year cycle counted from zero for year y is (y - 1) mod 19
  function automatic logic leap_cur(input logic [4:0] cyc);
    return cyc == 5'd2 || cyc == 5'd5 || cyc == 5'd7 || cyc == 5'd10 ||
           cyc == 5'd13 || cyc == 5'd16 || cyc == 5'd18;
  endfunction

  function automatic logic leap_prev(input logic [4:0] cyc);
    return cyc == 5'd0 || cyc == 5'd3 || cyc == 5'd6 || cyc == 5'd8 ||
           cyc == 5'd11 || cyc == 5'd14 || cyc == 5'd17;
  endfunction

endpackage

[design/hebrew_calendar_day_conversion_unit.sv]
// hebrew calendar date <-> fixed day count converter, top level sequencer
// depends on hcdc_pkg, hcdc_new_year and the assertion macro header
//
// usage: one request channel (in_valid_i/in_ready_o) carries operation, year, month,
// day and day_number; operation 0 turns a date into a day count, 1 turns a day count
// into a date. each item gives one result item on out_valid_o/out_ready_i with both
// forms, the weekday, the leap flag and an invalid flag (other fields zero then).
// in_ready_o is high only while the sequencer is idle; one item is worked at a time.
// every tishrei 1 is found by the shared new-year unit, and months are walked one per
// cycle. date to day count takes two evaluations and up to 12 month steps; day count
// to date takes evaluations of the estimated year and the next plus one per year
// stepped (at most seven in all). a zero field, a year above 9999, or a day count
// before the first year, is flagged without any new-year evaluation.
// the result sits in an output register; a new item is taken while it waits, and the
// next result is held back until the receiver takes the previous one.
// reset (rst_ni low, asynchronous) clears the sequencer and the output valid.
`include "hebrew_calendar_day_conversion_unit_macros.svh"

module hebrew_calendar_day_conversion_unit import hcdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [13:0]        year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic signed [22:0] day_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [22:0] result_day_number_o,
  output logic [13:0]        result_year_o,
  output logic [3:0]         result_month_o,
  output logic [4:0]         result_day_o,
  output logic [2:0]         weekday_o,
  output logic               leap_year_o,
  output logic               invalid_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEst  = 3'd1;
  localparam logic [2:0] StNyS  = 3'd2;
  localparam logic [2:0] StNyE  = 3'd3;
  localparam logic [2:0] StLen  = 3'd4;
  localparam logic [2:0] StWalk = 3'd5;
  localparam logic [2:0] StWday = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0]  state_q, state_d;
  logic        out_valid_q;
  logic        op_q, bad_q, leap_q;
  logic [13:0] y_q;
  logic [3:0]  month_q, mcur_q;
  logic [4:0]  day_q;
  logic [22:0] days_q;
  logic [21:0] s_q, e_q, dtot_q;
  logic [8:0]  rem_q;
  logic [19:0] q7_q;

  logic signed [22:0] res_dn_q;
  logic [13:0] res_year_q;
  logic [3:0]  res_month_q;
  logic [4:0]  res_day_q;
  logic [2:0]  res_wday_q;
  logic        res_leap_q, res_inv_q;

  ny_req_t     ny_req;
  ny_rsp_t     ny_rsp;

  logic        in_accept, out_slot;
  logic [23:0] days_sum;
  logic        lo_bad, date_bad;
  logic [46:0] est_prod;
  logic [14:0] est, est_m2;
  logic [13:0] est_year;
  logic        nys_month_bad, nye_step, nye_top_bad;
  logic [21:0] ylen_full;
  logic [8:0]  ylen;
  logic        long_hv, short_kv;
  logic [4:0]  cur_len, tgt_len;
  logic        len_bad, walk_done;
  logic [22:0] off_full;
  logic [44:0] q7_prod;
  logic [21:0] wk_full;
  logic [2:0]  wk_r;
  logic [22:0] dn_full;

  hcdc_new_year u_new_year (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ny_req),
    .rsp_o  (ny_rsp)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_slot   = !out_valid_q || out_ready_i;

  assign days_sum = {day_number_i[22], day_number_i} + EpochW;
  assign lo_bad   = days_sum[23] || (days_sum < FirstDayW);
  assign date_bad = (year_i == 14'd0) || (year_i > MaxYear) || (month_i == 4'd0) ||
                    (day_i == 5'd0);

  // year estimate from a slightly long mean year, backed off so the search only steps up
  assign est_prod = {24'd0, days_q} * {23'd0, RecipYear};
  assign est      = est_prod[46:32];
  assign est_m2   = est - 15'd2;
  assign est_year = (est > EstHigh) ? MaxYear : (est < 15'd3) ? 14'd1 : est_m2[13:0];

  assign nys_month_bad = !op_q && (month_q > (ny_rsp.leap ? MonthAdarII : MonthAdar));
  assign nye_step      = op_q && (y_q < MaxYear) && ({1'b0, ny_rsp.days} <= days_q);
  assign nye_top_bad   = op_q && (y_q == MaxYear) && ({1'b0, ny_rsp.days} <= days_q);

  // year length ends in 5 for a long heshvan and in 3 for a short kislev
  assign ylen_full = e_q - s_q;
  assign ylen      = ylen_full[8:0];
  assign long_hv   = (ylen == 9'd355) || (ylen == 9'd385);
  assign short_kv  = (ylen == 9'd353) || (ylen == 9'd383);
  assign cur_len   = month_len(mcur_q, leap_q, long_hv, short_kv);
  assign tgt_len   = month_len(month_q, leap_q, long_hv, short_kv);
  assign len_bad   = !op_q && (day_q > tgt_len);
  assign walk_done = op_q ? (rem_q <= {4'd0, cur_len}) : (mcur_q == month_q);
  assign off_full  = days_q - {1'b0, s_q};

  assign q7_prod = {23'd0, dtot_q} * {22'd0, Recip7};
  assign wk_full = dtot_q - ({2'd0, q7_q} * 22'd7);
  assign wk_r    = wk_full[2:0];
  assign dn_full = {1'b0, dtot_q} - Epoch;

  always_comb begin
    ny_req = '0;
    unique case (state_q)
      StIdle: if (in_accept && !operation_i && !date_bad) begin
        ny_req.start = 1'b1;
        ny_req.year  = year_i;
      end
      StEst: begin
        ny_req.start = 1'b1;
        ny_req.year  = est_year;
      end
      StNyS: if (ny_rsp.done && !nys_month_bad) begin
        ny_req.start = 1'b1;
        ny_req.year  = y_q + 14'd1;
      end
      StNyE: if (ny_rsp.done && nye_step) begin
        ny_req.start = 1'b1;
        ny_req.year  = y_q + 14'd2;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_accept) begin
        if (operation_i) state_d = lo_bad ? StOut : StEst;
        else state_d = date_bad ? StOut : StNyS;
      end
      StEst:  state_d = StNyS;
      StNyS:  if (ny_rsp.done) state_d = nys_month_bad ? StOut : StNyE;
      StNyE:  if (ny_rsp.done) begin
        priority if (nye_step) state_d = StNyE;
        else if (nye_top_bad) state_d = StOut;
        else state_d = StLen;
      end
      StLen:  state_d = len_bad ? StOut : StWalk;
      StWalk: if (walk_done) state_d = StWday;
      StWday: state_d = StOut;
      StOut:  if (out_slot) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && out_slot) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (in_accept) begin
        op_q    <= operation_i;
        y_q     <= year_i;
        month_q <= month_i;
        day_q   <= day_i;
        days_q  <= days_sum[22:0];
        bad_q   <= operation_i ? lo_bad : date_bad;
      end
      StEst: y_q <= est_year;
      StNyS: if (ny_rsp.done) begin
        s_q    <= ny_rsp.days;
        leap_q <= ny_rsp.leap;
        bad_q  <= nys_month_bad;
      end
      StNyE: if (ny_rsp.done) begin
        if (nye_step) begin
          y_q    <= y_q + 14'd1;
          s_q    <= ny_rsp.days;
          leap_q <= ny_rsp.leap;
        end else begin
          e_q   <= ny_rsp.days;
          bad_q <= nye_top_bad;
        end
      end
      StLen: begin
        bad_q  <= len_bad;
        mcur_q <= MonthTishrei;
        rem_q  <= op_q ? off_full[8:0] : 9'd0;
      end
      StWalk: begin
        if (walk_done) begin
          if (op_q) begin
            day_q   <= rem_q[4:0];
            month_q <= mcur_q;
            dtot_q  <= days_q[21:0];
          end else begin
            dtot_q <= s_q + {13'd0, rem_q} + {17'd0, day_q};
          end
        end else begin
          mcur_q <= next_month(mcur_q, leap_q);
          rem_q  <= op_q ? rem_q - {4'd0, cur_len} : rem_q + {4'd0, cur_len};
        end
      end
      StWday: q7_q <= q7_prod[44:25];
      default: ;
    endcase
  end

  // weekday: day count mod 7 is one below the count from the calendar base
  always_ff @(posedge clk_i) begin
    if (state_q == StOut && out_slot) begin
      if (bad_q) begin
        res_dn_q    <= '0;
        res_year_q  <= '0;
        res_month_q <= '0;
        res_day_q   <= '0;
        res_wday_q  <= '0;
        res_leap_q  <= 1'b0;
        res_inv_q   <= 1'b1;
      end else begin
        res_dn_q    <= $signed(dn_full);
        res_year_q  <= y_q;
        res_month_q <= month_q;
        res_day_q   <= day_q;
        res_wday_q  <= (wk_r == 3'd0) ? 3'd7 : wk_r;
        res_leap_q  <= leap_q;
        res_inv_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_day_number_o = res_dn_q;
  assign result_year_o       = res_year_q;
  assign result_month_o      = res_month_q;
  assign result_day_o        = res_day_q;
  assign weekday_o           = res_wday_q;
  assign leap_year_o         = res_leap_q;
  assign invalid_o           = res_inv_q;

  `HCDC_ASSERT_IMPL(a_ny_owner, ny_rsp.done, state_q == StNyS || state_q == StNyE, "stray new-year result")
  `HCDC_ASSERT_IMPL(a_res_fields, out_valid_o && !invalid_o, weekday_o != 3'd0 && result_month_o != 4'd0, "valid item with empty date field")
  `HCDC_ASSERT_IMPL(a_walk_range, state_q == StWalk, rem_q <= YearLenMax, "month walk ran past the year")

endmodule

[design/hcdc_new_year.sv]
// multi-cycle new-year unit: day count of tishrei 1 of a year from molad and postponements
// depends on hcdc_pkg and the assertion macro header
`include "hebrew_calendar_day_conversion_unit_macros.svh"

module hcdc_new_year import hcdc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ny_req_t req_i,
  output ny_rsp_t rsp_o
);

  localparam logic [3:0] StQ19    = 4'd0;
  localparam logic [3:0] StCyc    = 4'd1;
  localparam logic [3:0] StMonths = 4'd2;
  localparam logic [3:0] StMq     = 4'd3;
  localparam logic [3:0] StMr     = 4'd4;
  localparam logic [3:0] StPe     = 4'd5;
  localparam logic [3:0] StPeq    = 4'd6;
  localparam logic [3:0] StHours  = 4'd7;
  localparam logic [3:0] StHd     = 4'd8;
  localparam logic [3:0] StDd     = 4'd9;
  localparam logic [3:0] StParts  = 4'd10;
  localparam logic [3:0] StAdj    = 4'd11;
  localparam logic [3:0] StDone   = 4'd12;

  logic        busy_q;
  logic [3:0]  step_q;
  logic        load;
  logic [13:0] yp_q;
  logic [9:0]  q19_q;
  logic [4:0]  cyc_q;
  logic        lp_cur_q, lp_prev_q;
  logic [16:0] months_q;
  logic [6:0]  mq_q;
  logic [10:0] mr_q;
  logic [19:0] pe_q;
  logic [9:0]  peq_q;
  logic [10:0] per_q;
  logic [20:0] hours_q;
  logic [16:0] hd_q;
  logic [4:0]  hr_q;
  logic [21:0] dd_q;
  logic [14:0] parts_q;
  logic [19:0] q7_q;
  logic [21:0] days_q;

  logic [29:0] q19_prod;
  logic [13:0] cyc_full;
  logic [7:0]  c7;
  logic [12:0] c7_prod;
  logic [16:0] months_d;
  logic [36:0] mq_prod;
  logic [16:0] mr_full;
  logic [19:0] pe_d;
  logic [39:0] peq_prod;
  logic [19:0] per_full;
  logic [20:0] hours_d;
  logic [42:0] hd_prod;
  logic [20:0] hr_full;
  logic [21:0] dd_d;
  logic [14:0] parts_d;
  logic [44:0] q7_prod;
  logic [21:0] w_full;
  logic [2:0]  w;
  logic        c1, c2;
  logic [3:0]  w_sum;
  logic [2:0]  w1;

  assign q19_prod = {16'd0, yp_q} * {14'd0, Recip19};
  assign cyc_full = yp_q - ({4'd0, q19_q} * 14'd19);
  assign c7       = {3'd0, cyc_q} * 8'd7 + 8'd1;
  // (7c + 1) / 19 for small c
  assign c7_prod  = {5'd0, c7} * 13'd27;
  assign months_d = {7'd0, q19_q} * {8'd0, CycleMonths} + {12'd0, cyc_q} * 17'd12 +
                    {13'd0, c7_prod[12:9]};
  assign mq_prod  = {20'd0, months_q} * {17'd0, Recip1080};
  assign mr_full  = months_q - ({10'd0, mq_q} * {6'd0, PartsHour});
  assign pe_d     = {9'd0, mr_q} * {10'd0, MoladStep} + {12'd0, MoladBase};
  assign peq_prod = {20'd0, pe_q} * {20'd0, Recip1080};
  assign per_full = pe_q - ({10'd0, peq_q} * {9'd0, PartsHour});
  assign hours_d  = 21'd5 + {4'd0, months_q} * 21'd12 + {14'd0, mq_q} * {11'd0, MoladStep} +
                    {11'd0, peq_q};
  assign hd_prod  = {22'd0, hours_q} * {21'd0, Recip24};
  assign hr_full  = hours_q - ({4'd0, hd_q} * 21'd24);
  assign dd_d     = 22'd1 + {5'd0, months_q} * 22'd29 + {5'd0, hd_q};
  assign parts_d  = {10'd0, hr_q} * {4'd0, PartsHour} + {4'd0, per_q};
  assign q7_prod  = {23'd0, dd_q} * {22'd0, Recip7};
  assign w_full   = dd_q - ({2'd0, q7_q} * 22'd7);
  assign w        = w_full[2:0];

  // molad postponements, then the days on which tishrei 1 may not fall
  assign c1    = (parts_q >= LimitLate) ||
                 (w == WdTue && parts_q >= LimitTue && !lp_cur_q) ||
                 (w == WdMon && parts_q >= LimitMon && lp_prev_q);
  assign w_sum = {1'b0, w} + {3'd0, c1};
  assign w1    = (w_sum == 4'd7) ? 3'd0 : w_sum[2:0];
  assign c2    = (w1 == 3'd0) || (w1 == WdWed) || (w1 == WdFri);

  assign rsp_o.done = busy_q && (step_q == StDone);
  assign rsp_o.days = days_q;
  assign rsp_o.leap = lp_cur_q;

  assign load = req_i.start && (!busy_q || rsp_o.done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StQ19;
    end else if (load) begin
      busy_q <= 1'b1;
      step_q <= StQ19;
    end else if (busy_q) begin
      if (step_q == StDone) busy_q <= 1'b0;
      else step_q <= step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      yp_q <= req_i.year - 14'd1;
    end else if (busy_q) begin
      unique case (step_q)
        StQ19:    q19_q <= q19_prod[29:20];
        StCyc:    cyc_q <= cyc_full[4:0];
        StMonths: begin
          months_q  <= months_d;
          lp_cur_q  <= leap_cur(cyc_q);
          lp_prev_q <= leap_prev(cyc_q);
        end
        StMq:     mq_q <= mq_prod[36:30];
        StMr:     mr_q <= mr_full[10:0];
        StPe:     pe_q <= pe_d;
        StPeq:    peq_q <= peq_prod[39:30];
        StHours: begin
          per_q   <= per_full[10:0];
          hours_q <= hours_d;
        end
        StHd:     hd_q <= hd_prod[42:26];
        StDd: begin
          hr_q <= hr_full[4:0];
          dd_q <= dd_d;
        end
        StParts: begin
          parts_q <= parts_d;
          q7_q    <= q7_prod[44:25];
        end
        StAdj:    days_q <= dd_q + {21'd0, c1} + {21'd0, c2};
        default: ;
      endcase
    end
  end

  `HCDC_ASSERT_NEXT(a_ny_start, req_i.start && !busy_q, busy_q && step_q == StQ19, "new-year unit did not start")
  `HCDC_ASSERT_NEXT(a_ny_run, busy_q && step_q != StDone, busy_q, "new-year unit stopped early")
  `HCDC_ASSERT_IMPL(a_ny_step, busy_q, step_q <= StDone, "new-year step out of range")

endmodule

[bench/hebrew_calendar_day_conversion_unit_test.sv]
// self-checking bench for the hebrew calendar date <-> day count converter
// depends on hcdc_pkg and the hebrew_calendar_day_conversion_unit rtl
module hebrew_calendar_day_conversion_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcdc_pkg::*;

  typedef struct packed {
    logic signed [22:0] dn;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [2:0]         wd;
    logic               leap;
    logic               bad;
  } conv_res_t;

  localparam logic OpToDays = 1'b0;
  localparam logic OpToDate = 1'b1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               operation_i = 1'b0;
  logic [13:0]        year_i = '0;
  logic [3:0]         month_i = '0;
  logic [4:0]         day_i = '0;
  logic signed [22:0] day_number_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [22:0] result_day_number_o;
  logic [13:0]        result_year_o;
  logic [3:0]         result_month_o;
  logic [4:0]         result_day_o;
  logic [2:0]         weekday_o;
  logic               leap_year_o;
  logic               invalid_o;

  conv_res_t expected_q[$];
  int        mismatches = 0;
  bit        idle_on = 1'b1;

  hebrew_calendar_day_conversion_unit u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("hebrew_calendar_day_conversion_unit verification failed");
    $finish;
  end

  function automatic bit is_leap(input longint y);
    return ((y * 7 + 1) % 19) < 7;
  endfunction

  // days from the calendar base to tishrei 1, with the postponement rules
  function automatic longint tishrei_one(input longint y);
    longint yp, cyc, months, pe, hours, dd, parts, w;
    yp = y - 1;
    cyc = yp % 19;
    months = 235 * (yp / 19) + 12 * cyc + (cyc * 7 + 1) / 19;
    pe = (months % 1080) * 793 + 204;
    hours = 5 + months * 12 + (months / 1080) * 793 + pe / 1080;
    dd = 1 + 29 * months + hours / 24;
    parts = (hours % 24) * 1080 + pe % 1080;
    w = dd % 7;
    if (parts >= 19440 || (w == 2 && parts >= 9924 && !is_leap(y)) ||
        (w == 1 && parts >= 16789 && is_leap(y - 1)))
      dd++;
    w = dd % 7;
    if (w == 0 || w == 3 || w == 5) dd++;
    return dd;
  endfunction

  function automatic longint days_in_month(input longint m, input bit leap, input longint ylen);
    if (m == 2 || m == 4 || m == 6 || m == 10 || m == 13) return 29;
    if (m == 12 && !leap) return 29;
    if (m == 8 && ylen % 10 != 5) return 29;
    if (m == 9 && ylen % 10 == 3) return 29;
    return 30;
  endfunction

  function automatic longint day_count_of(input longint y, input longint m, input longint d);
    longint start, ylen, sum, last;
    bit leap;
    start = tishrei_one(y);
    ylen = tishrei_one(y + 1) - start;
    leap = is_leap(y);
    last = leap ? 13 : 12;
    sum = d;
    if (m < 7) begin
      for (longint k = 7; k <= last; k++) sum += days_in_month(k, leap, ylen);
      for (longint k = 1; k < m; k++) sum += days_in_month(k, leap, ylen);
    end else begin
      for (longint k = 7; k < m; k++) sum += days_in_month(k, leap, ylen);
    end
    return start + sum - 1373429;
  endfunction

  function automatic conv_res_t convert(input logic op, input logic [13:0] yr,
                                        input logic [3:0] mo, input logic [4:0] dy,
                                        input logic signed [22:0] dnum);
    conv_res_t r;
    longint y, m, d, fixed, dn, lo, hi, ylen, wd;
    bit bad, leap;
    r = '0;
    y = yr; m = mo; d = dy; dn = dnum;
    bad = 1'b0; fixed = 0;
    if (op == OpToDays) begin
      if (y < 1 || y > 9999 || m < 1 || m > (is_leap(y) ? 13 : 12) || d < 1) bad = 1'b1;
      else begin
        ylen = tishrei_one(y + 1) - tishrei_one(y);
        if (d > days_in_month(m, is_leap(y), ylen)) bad = 1'b1;
        else fixed = day_count_of(y, m, d);
      end
    end else begin
      lo = tishrei_one(1) - 1373429;
      hi = tishrei_one(10000) - 1373429;
      if (dn < lo || dn >= hi) bad = 1'b1;
      else begin
        fixed = dn;
        y = (dn + 1373429) / 366;
        if (y < 1) y = 1;
        while (y < 9999 && dn >= tishrei_one(y + 1) - 1373429) y++;
        ylen = tishrei_one(y + 1) - tishrei_one(y);
        leap = is_leap(y);
        m = (dn < day_count_of(y, 1, 1)) ? 7 : 1;
        while (m < 13 && dn > day_count_of(y, m, days_in_month(m, leap, ylen))) m++;
        d = dn - day_count_of(y, m, 1) + 1;
      end
    end
    if (bad) begin
      r.bad = 1'b1;
      return r;
    end
    wd = fixed % 7;
    if (wd < 0) wd += 7;
    r.dn = fixed[22:0];
    r.year = y[13:0];
    r.month = m[3:0];
    r.day = d[4:0];
    r.wd = 3'(wd + 1);
    r.leap = is_leap(y);
    return r;
  endfunction

  task automatic send_request(input logic op, input logic [13:0] yr, input logic [3:0] mo,
                              input logic [4:0] dy, input logic signed [22:0] dnum);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 19)) @(negedge clk_i);
    operation_i <= op;
    year_i <= yr;
    month_i <= mo;
    day_i <= dy;
    day_number_i <= dnum;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(convert(op, yr, mo, dy, dnum));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // receiver side, with random stall bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    conv_res_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{result_day_number_o, result_year_o, result_month_o, result_day_o,
              weekday_o, leap_year_o, invalid_o};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_request(OpToDays, 14'd1, 4'd7, 5'd1, '0);
    send_request(OpToDays, 14'd9999, 4'd6, 5'd29, '0);
    send_request(OpToDays, 14'd5784, 4'd13, 5'd29, '0);
    send_request(OpToDays, 14'd5785, 4'd13, 5'd1, '0);
    send_request(OpToDays, 14'd5784, 4'd8, 5'd30, '0);
    send_request(OpToDays, 14'd5784, 4'd9, 5'd30, '0);
    send_request(OpToDays, 14'd0, 4'd1, 5'd1, '0);
    send_request(OpToDays, 14'd10000, 4'd1, 5'd1, '0);
    send_request(OpToDays, 14'h3fff, 4'hf, 5'h1f, '0);
    send_request(OpToDays, 14'd5000, 4'd0, 5'd1, '0);
    send_request(OpToDays, 14'd5000, 4'd1, 5'd0, '0);
    send_request(OpToDays, 14'd5000, 4'd2, 5'd30, '0);
    send_request(OpToDate, '0, '0, '0, -23'sd1373427);
    send_request(OpToDate, '0, '0, '0, -23'sd1373428);
    send_request(OpToDate, '0, '0, '0, 23'sd0);
    send_request(OpToDate, '0, '0, '0, 23'sd2278000);
    send_request(OpToDate, '0, '0, '0, 23'sd2300000);
    send_request(OpToDate, 14'h3fff, 4'hf, 5'h1f, 23'sh3fffff);
    send_request(OpToDate, '0, '0, '0, -23'sh400000);
    send_request(OpToDate, '0, '0, '0, 23'sd739000);
  endtask

  task automatic test_random(input int count);
    logic signed [22:0] dn;
    for (int i = 0; i < count; i++) begin
      dn = 23'(int'($urandom_range(0, 3673428)) - 1373428);
      case ($urandom_range(0, 9))
        0: send_request(OpToDays, 14'($urandom), 4'($urandom), 5'($urandom), 23'($urandom));
        1: send_request(OpToDate, 14'($urandom), 4'($urandom), 5'($urandom), 23'($urandom));
        2, 3, 4, 5: send_request(OpToDays, 14'($urandom_range(1, 9999)),
                                 4'($urandom_range(1, 13)), 5'($urandom_range(1, 30)), dn);
        default: send_request(OpToDate, 14'($urandom), 4'($urandom), 5'($urandom), dn);
      endcase
    end
  endtask

  initial begin
    int guard;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1100);
    idle_on = 1'b0;
    test_random(200);
    guard = 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("hebrew_calendar_day_conversion_unit verification clean");
    else
      $display("hebrew_calendar_day_conversion_unit verification failed");
    $finish;
  end
endmodule
